// ===== sv/svpwm_seven_segment_duty_core_assert.svh =====
// Assertion macros shared by the duty core.
`ifndef SVPWM_SEVEN_SEGMENT_DUTY_CORE_ASSERT_SVH
`define SVPWM_SEVEN_SEGMENT_DUTY_CORE_ASSERT_SVH

// Condition checked at every clock edge outside reset.
`define SVPWM_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent checked in the same cycle as its antecedent.
`define SVPWM_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/svpwm_pkg.sv =====
// Types, constants and helpers for the SVPWM duty core.
`timescale 1ns / 1ps
package svpwm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FRAC_W     = SAMPLE_W - 1;
  localparam int WIDE_SHIFT = 30;
  localparam int WIDE_W     = SAMPLE_W + 33;
  localparam int SMALL_W    = SAMPLE_W + 3;
  localparam int DIV_SHIFT  = SAMPLE_W + 2;
  localparam int DIV_PW     = 2 * SAMPLE_W + 2;

  localparam logic [WIDE_W-1:0] ONE_WIDE   = WIDE_W'(1) << (FRAC_W + WIDE_SHIFT);
  localparam logic [WIDE_W-1:0] ROUND_HALF = WIDE_W'(1) << (WIDE_SHIFT - 1);
  localparam logic [SAMPLE_W-1:0] ONE_OUT  = SAMPLE_W'(1) << FRAC_W;

  // sqrt(3)/2 in Q30, and (2*sqrt3half - 1)/3 which is exact as an integer
  localparam logic signed [31:0] SQRT3_HALF_Q30 = 32'sd929887697;
  localparam logic signed [31:0] TWO_THIRDS_K   = 32'sd619925131;

  // floor(u/3) = (u * DIV3_RECIP) >> DIV_SHIFT for u below 2^(SAMPLE_W+1)
  localparam logic [SAMPLE_W:0] DIV3_RECIP =
    (SAMPLE_W + 1)'(((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3);
  localparam logic [SAMPLE_W:0] DIV3_BIAS = (SAMPLE_W + 1)'(3) << FRAC_W;

  typedef enum logic [1:0] {PH_A, PH_B, PH_C} phase_t;

  typedef struct packed {
    phase_t min_ph;
    phase_t max_ph;
  } extreme_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] v_alpha;
    logic signed [SAMPLE_W-1:0] v_beta;
  } svpwm_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] duty_a;
    logic [SAMPLE_W-1:0] duty_b;
    logic [SAMPLE_W-1:0] duty_c;
  } svpwm_out_t;

  // clamp to 1.0, round half up, drop to output precision
  function automatic logic [SAMPLE_W-1:0] wide_to_duty(input logic [WIDE_W:0] wide);
    logic [WIDE_W:0] sat;
    sat = (wide > {1'b0, ONE_WIDE}) ? {1'b0, ONE_WIDE} : wide;
    sat = sat + {1'b0, ROUND_HALF};
    return sat[WIDE_SHIFT +: SAMPLE_W];
  endfunction

endpackage

// ===== sv/svpwm_extreme.sv =====
// Picks the phases holding the smallest and largest projected voltage.
`timescale 1ns / 1ps
module svpwm_extreme (
  input  logic signed [svpwm_pkg::WIDE_W-1:0] ph_a,
  input  logic signed [svpwm_pkg::WIDE_W-1:0] ph_b,
  input  logic signed [svpwm_pkg::WIDE_W-1:0] ph_c,
  output svpwm_pkg::extreme_t                 ext
);
  import svpwm_pkg::*;

  logic lt_ba, lt_ca, lt_cb;
  logic gt_ba, gt_ca, gt_cb;

  assign lt_ba = ph_b < ph_a;
  assign lt_ca = ph_c < ph_a;
  assign lt_cb = ph_c < ph_b;
  assign gt_ba = ph_b > ph_a;
  assign gt_ca = ph_c > ph_a;
  assign gt_cb = ph_c > ph_b;

  always_comb begin
    if (!lt_ba && !lt_ca) begin
      ext.min_ph = PH_A;
    end else if (lt_ba && !lt_cb) begin
      ext.min_ph = PH_B;
    end else begin
      ext.min_ph = PH_C;
    end
    if (!gt_ba && !gt_ca) begin
      ext.max_ph = PH_A;
    end else if (gt_ba && !gt_cb) begin
      ext.max_ph = PH_B;
    end else begin
      ext.max_ph = PH_C;
    end
  end

endmodule

// ===== sv/svpwm_seven_segment_duty_core.sv =====
// Top level of the seven-segment SVPWM duty core (min/max injection).
`timescale 1ns / 1ps
// Takes one alpha/beta word (signed Q1.15) per clock while in_ready is high
// and returns phase duties a, b, c (unsigned Q1.15, 32768 = 1.0). Six register
// stages: input capture, multiplies, phase projection, min/max search with 2/3
// scaling, active and zero-vector offset, then rounding into the output
// register. out_valid is the valid bit of the output register; throughput is
// one word per clock while out_ready stays high.
// A low out_ready stalls each full stage back to the first bubble via a ready
// chain; any bubble lets a new word in, so nothing is dropped or repeated.
module svpwm_seven_segment_duty_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  svpwm_pkg::svpwm_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output svpwm_pkg::svpwm_out_t out_data
);
  import svpwm_pkg::*;

  localparam int STAGES = 6;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  // stage 0: input capture
  logic signed [SAMPLE_W-1:0] s0_a, s0_b;
  // stage 1: products
  logic signed [SAMPLE_W-1:0] s1_a, s1_b;
  logic signed [WIDE_W-1:0]   s1_kb, s1_qb;
  logic [DIV_PW-1:0]          s1_div;
  logic [SAMPLE_W:0]          div_u;
  // stage 2: phase voltages and beta/3 corrections
  logic signed [WIDE_W-1:0]   s2_ph0, s2_ph1, s2_ph2, s2_qb;
  logic signed [SMALL_W-1:0]  s2_f1, s2_g1, s2_f2, s2_g2;
  logic signed [SAMPLE_W+1:0] q_s;
  logic signed [SAMPLE_W+2:0] r_full;
  logic [1:0]                 r;
  logic signed [WIDE_W-1:0]   half_a, ph0_next;
  // stage 3: scaled pairwise differences, extremes
  extreme_t                   ext, s3_ext;
  logic signed [WIDE_W-1:0]   s3_t01, s3_t10, s3_t02, s3_t20, s3_t12, s3_t21;
  // stage 4: per-phase terms and offset
  logic [WIDE_W-1:0]          t0_next, t1_next, t2_next, active, active_sat, off_next;
  logic [WIDE_W-1:0]          s4_t0, s4_t1, s4_t2, s4_off;
  // stage 5: output register
  svpwm_out_t                 s5_out;

  // ready chain
  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[STAGES-1];
  assign out_data  = s5_out;

  // stage 0
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_a <= in_data.v_alpha;
      s0_b <= in_data.v_beta;
    end
  end

  // stage 1: beta times sqrt3/2, beta times the 2/3 constant, beta/3 reciprocal
  assign div_u = {s0_b[SAMPLE_W-1], s0_b} + DIV3_BIAS;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_a   <= s0_a;
      s1_b   <= s0_b;
      s1_kb  <= WIDE_W'(SQRT3_HALF_Q30) * WIDE_W'(s0_b);
      s1_qb  <= WIDE_W'(TWO_THIRDS_K) * WIDE_W'(s0_b);
      s1_div <= DIV_PW'(div_u) * DIV_PW'(DIV3_RECIP);
    end
  end

  // stage 2: q = floor(b/3), r = b mod 3
  always_comb begin
    q_s = $signed({2'b00, s1_div[DIV_SHIFT +: SAMPLE_W]})
        - $signed((SAMPLE_W + 2)'(1) << FRAC_W);
    r_full = (SAMPLE_W + 3)'(s1_b) - (SAMPLE_W + 3)'(q_s) - ((SAMPLE_W + 3)'(q_s) <<< 1);
    r = r_full[1:0];
    ph0_next = WIDE_W'(s1_a) <<< WIDE_SHIFT;
    half_a   = WIDE_W'(s1_a) <<< (WIDE_SHIFT - 1);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_ph0 <= ph0_next;
      s2_ph1 <= s1_kb - half_a;
      s2_ph2 <= -half_a - s1_kb;
      s2_qb  <= s1_qb;
      // floor(b/3), floor(-b/3), floor(2b/3), floor(-2b/3)
      s2_f1  <= SMALL_W'(q_s);
      s2_g1  <= -SMALL_W'(q_s) - SMALL_W'(r != 2'd0);
      s2_f2  <= (SMALL_W'(q_s) <<< 1) + SMALL_W'(r == 2'd2);
      s2_g2  <= -(SMALL_W'(q_s) <<< 1) - SMALL_W'(r);
    end
  end

  // stage 3: floor(2*(ph_i - ph_j)/3) for every ordered pair
  svpwm_extreme u_extreme (
    .ph_a (s2_ph0),
    .ph_b (s2_ph1),
    .ph_c (s2_ph2),
    .ext  (ext)
  );

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_ext <= ext;
      s3_t01 <= s2_ph0 - s2_qb + WIDE_W'(s2_g1);
      s3_t10 <= s2_qb - s2_ph0 + WIDE_W'(s2_f1);
      s3_t02 <= s2_ph0 + s2_qb + WIDE_W'(s2_f1);
      s3_t20 <= -s2_ph0 - s2_qb + WIDE_W'(s2_g1);
      s3_t12 <= (s2_qb <<< 1) + WIDE_W'(s2_f2);
      s3_t21 <= WIDE_W'(s2_g2) - (s2_qb <<< 1);
    end
  end

  // stage 4: each phase measured from the minimum, active time from the maximum
  always_comb begin
    case (s3_ext.min_ph)
      PH_B: begin
        t0_next = s3_t01;
        t1_next = '0;
        t2_next = s3_t21;
      end
      PH_C: begin
        t0_next = s3_t02;
        t1_next = s3_t12;
        t2_next = '0;
      end
      default: begin
        t0_next = '0;
        t1_next = s3_t10;
        t2_next = s3_t20;
      end
    endcase
    case (s3_ext.max_ph)
      PH_B:    active = t1_next;
      PH_C:    active = t2_next;
      default: active = t0_next;
    endcase
    active_sat = (active > ONE_WIDE) ? ONE_WIDE : active;
    off_next   = (ONE_WIDE - active_sat) >> 1;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_t0  <= t0_next;
      s4_t1  <= t1_next;
      s4_t2  <= t2_next;
      s4_off <= off_next;
    end
  end

  // stage 5: add offset, saturate, round
  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_out.duty_a <= wide_to_duty((WIDE_W + 1)'(s4_t0) + (WIDE_W + 1)'(s4_off));
      s5_out.duty_b <= wide_to_duty((WIDE_W + 1)'(s4_t1) + (WIDE_W + 1)'(s4_off));
      s5_out.duty_c <= wide_to_duty((WIDE_W + 1)'(s4_t2) + (WIDE_W + 1)'(s4_off));
    end
  end

`include "svpwm_seven_segment_duty_core_assert.svh"

  `SVPWM_ASSERT_IMPLIES(a_full_when_stalled, !in_ready, &vld, "input stalled with a bubble")
  `SVPWM_ASSERT_IMPLIES(a_min_phase_zero, vld[4], (s4_t0 == '0) || (s4_t1 == '0) || (s4_t2 == '0), "no phase at zero offset from minimum")
  `SVPWM_ASSERT_IMPLIES(a_offset_split, vld[3], (((off_next << 1) + active_sat) == ONE_WIDE) || (((off_next << 1) + active_sat) == (ONE_WIDE - 1)), "zero-vector split mismatch")
  `SVPWM_ASSERT_IMPLIES(a_duty_range, out_valid, (out_data.duty_a <= ONE_OUT) && (out_data.duty_b <= ONE_OUT) && (out_data.duty_c <= ONE_OUT), "duty above 1.0")

endmodule
